FILE: rtl/core/tni_pkg.sv
// ----------------------------------------------------------------------------
// tni_pkg
// Shared widths, types and helpers for the triangle normal interpolator.
// ----------------------------------------------------------------------------
package tni_pkg;

	localparam int CRD_W   = 32;               // Q16.16 position
	localparam int NRM_W   = 16;               // Q2.14 normal
	localparam int DIF_W   = CRD_W + 1;        // position difference
	localparam int MOP_W   = DIF_W + 1;        // multiplier operand
	localparam int ACC_W   = 70;               // accumulator
	localparam int DIV_NW  = 96;               // dividend bits
	localparam int DIV_DW  = 64;               // divisor bits
	localparam int SQ_XW   = 64;               // radicand bits
	localparam int SQ_RW   = SQ_XW / 2;        // root bits
	localparam int MUL_CW  = $clog2(MOP_W + 1);
	localparam int DIV_CW  = $clog2(DIV_NW + 1);
	localparam int SQ_CW   = $clog2(SQ_RW + 1);
	localparam int NORM_BITS = 31;
	localparam int WGT_FRAC  = 16;
	localparam int NRM_FRAC  = NRM_W - 2;

	localparam int IN_DW  = 3 * CRD_W + 3 * NRM_W;
	localparam int IN_UW  = 3;
	localparam int OUT_DW = 6 * NRM_W + 2 * CRD_W;
	localparam int OUT_UW = 1;

	localparam logic FN_LOAD  = 1'b0;
	localparam logic FN_QUERY = 1'b1;
	localparam logic [1:0] NUM_SLOTS = 2'd3;

	localparam logic [DIV_DW-1:0] RATIO_MAX = {2'b00, {(DIV_DW-2){1'b1}}};
	localparam logic [SQ_RW+1:0]  WGT_ONE   = (SQ_RW+2)'(1) << WGT_FRAC;

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [MOP_W-1:0] mop_t;
	typedef logic signed [DIF_W-1:0] dif_t;

	localparam acc_t N16_MAX = (acc_t'(1) <<< (NRM_W - 1)) - acc_t'(1);
	localparam acc_t N16_MIN = -(acc_t'(1) <<< (NRM_W - 1));
	localparam acc_t C32_MAX = (acc_t'(1) <<< (CRD_W - 1)) - acc_t'(1);
	localparam acc_t C32_MIN = -(acc_t'(1) <<< (CRD_W - 1));

	typedef struct packed {
		logic go;
		logic first;  // clear accumulator before this product
		logic sub;    // subtract this product
	} mac_cmd_t;

	// corner c, axis k -> flat index 3c+k
	function automatic logic [3:0] idx9(logic [1:0] c, logic [1:0] k);
		return 4'({2'b00, c} * 4'd3 + {2'b00, k});
	endfunction

	function automatic logic [1:0] nxt3(logic [1:0] k);
		return (k == 2'd2) ? 2'd0 : k + 2'd1;
	endfunction

	function automatic logic [ACC_W-1:0] mag_acc(acc_t x);
		return x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
	endfunction

	function automatic logic signed [NRM_W-1:0] rnd_sat16(acc_t x);
		acc_t y;
		y = (x + (acc_t'(1) <<< (WGT_FRAC - 1))) >>> WGT_FRAC;
		if (y > N16_MAX) return N16_MAX[NRM_W-1:0];
		else if (y < N16_MIN) return N16_MIN[NRM_W-1:0];
		else return y[NRM_W-1:0];
	endfunction

	function automatic logic signed [CRD_W-1:0] rnd_sat32(acc_t x);
		acc_t y;
		y = (x + (acc_t'(1) <<< (NRM_FRAC - 1))) >>> NRM_FRAC;
		if (y > C32_MAX) return C32_MAX[CRD_W-1:0];
		else if (y < C32_MIN) return C32_MIN[CRD_W-1:0];
		else return y[CRD_W-1:0];
	endfunction

endpackage

FILE: rtl/core/tni_mac.sv
// ----------------------------------------------------------------------------
// tni_mac
// Bit-serial signed multiply-accumulate, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
module tni_mac import tni_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_cmd_t cmd,
	input  mop_t     a,
	input  mop_t     b,
	output logic     done,
	output acc_t     acc
);

	logic [ACC_W-1:0] mcd_q;
	logic [MOP_W-1:0] mpl_q;
	logic [MUL_CW-1:0] cnt_q;
	logic neg_q, busy_q, done_q;
	acc_t acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (cmd.go) begin
				busy_q <= 1'b1;
				cnt_q  <= MUL_CW'(MOP_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == MUL_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.go) begin
			mcd_q <= ACC_W'(a[MOP_W-1] ? MOP_W'(-a) : MOP_W'(a));
			mpl_q <= b[MOP_W-1] ? MOP_W'(-b) : MOP_W'(b);
			neg_q <= a[MOP_W-1] ^ b[MOP_W-1] ^ cmd.sub;
			if (cmd.first) acc_q <= '0;
		end else if (busy_q) begin
			if (mpl_q[0]) acc_q <= neg_q ? acc_q - $signed(mcd_q) : acc_q + $signed(mcd_q);
			mcd_q <= mcd_q << 1;
			mpl_q <= mpl_q >> 1;
		end
	end

	assign done = done_q;
	assign acc  = acc_q;

endmodule

FILE: rtl/core/tni_div.sv
// ----------------------------------------------------------------------------
// tni_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tni_div import tni_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              go,
	input  logic [DIV_NW-1:0] num,
	input  logic [DIV_DW-1:0] den,
	output logic              done,
	output logic [DIV_NW-1:0] quo
);

	logic [DIV_NW-1:0] num_q, quo_q;
	logic [DIV_DW-1:0] den_q, rem_q;
	logic [DIV_CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [DIV_DW:0] trial, diff;
	logic ge;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign diff  = trial - {1'b0, den_q};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CW'(DIV_NW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			num_q <= num_q << 1;
			rem_q <= ge ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quo  = quo_q;

endmodule

FILE: rtl/core/tni_sqrt.sv
// ----------------------------------------------------------------------------
// tni_sqrt
// Digit-by-digit integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module tni_sqrt import tni_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             go,
	input  logic [SQ_XW-1:0] x,
	output logic             done,
	output logic [SQ_RW-1:0] root
);

	logic [SQ_XW-1:0] x_q;
	logic [SQ_RW+1:0] rem_q;
	logic [SQ_RW-1:0] root_q;
	logic [SQ_CW-1:0] cnt_q;
	logic busy_q, done_q;
	logic [SQ_RW+3:0] t, trial, diff;
	logic ge;

	assign t     = {rem_q, x_q[SQ_XW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign diff  = t - trial;
	assign ge    = t >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (go) begin
				busy_q <= 1'b1;
				cnt_q  <= SQ_CW'(SQ_RW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == SQ_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			x_q    <= x;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			x_q    <= x_q << 2;
			rem_q  <= ge ? diff[SQ_RW+1:0] : t[SQ_RW+1:0];
			root_q <= {root_q[SQ_RW-2:0], ge};
		end
	end

	assign done = done_q;
	assign root = root_q;

endmodule

FILE: rtl/core/triangle_normal_interpolator.sv
// ----------------------------------------------------------------------------
// triangle_normal_interpolator
// Barycentric normal interpolation over one stored triangle.
// ----------------------------------------------------------------------------
// A load beat (tuser func = 0) writes one corner's position and normal; slot
// 3 is dropped. A query beat (func = 1) brings a point and yields one result
// beat: the corner normals blended with square-root barycentric weights, the
// unit face normal, the plane offset and the signed distance of the point, or
// only the degenerate flag (all data zero) when the triangle has zero area.
// Most of the work of a query is the one bit per cycle multiply-accumulate
// unit (45 products: cross products, sums of squares, blend and dot
// products); the rest is the radix-2 divider (for each of three face
// components and two weight ratios), three square roots and two normalizing
// shift passes. A weight ratio with a zero numerator skips its division, so
// a point on a corner or an edge finishes sooner. A zero-area triangle stops
// after the 18 cross-product passes. The input side takes no beat while a
// query is at work; a finished result sits in the output register and the
// next beat may be taken while it waits.
// ----------------------------------------------------------------------------
module triangle_normal_interpolator import tni_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	// pos_x, pos_y, pos_z, nrm_in_x, nrm_in_y, nrm_in_z
	input  logic [IN_DW-1:0]  s_tdata,
	// func, vertex_slot
	input  logic [IN_UW-1:0]  s_tuser,
	output logic              m_tvalid,
	input  logic              m_tready,
	// interp_x, interp_y, interp_z, face_x, face_y, face_z, plane_offset,
	// signed_distance
	output logic [OUT_DW-1:0] m_tdata,
	// degenerate
	output logic [OUT_UW-1:0] m_tuser
);

	localparam logic [3:0] S_IDLE   = 4'd0;
	localparam logic [3:0] S_CROSS  = 4'd1;
	localparam logic [3:0] S_CHECK  = 4'd2;
	localparam logic [3:0] S_NRM3   = 4'd3;
	localparam logic [3:0] S_SQF    = 4'd4;
	localparam logic [3:0] S_SQRTL  = 4'd5;
	localparam logic [3:0] S_FACE   = 4'd6;
	localparam logic [3:0] S_NRM9   = 4'd7;
	localparam logic [3:0] S_SQG    = 4'd8;
	localparam logic [3:0] S_RATIO  = 4'd9;
	localparam logic [3:0] S_ROOT   = 4'd10;
	localparam logic [3:0] S_INTERP = 4'd11;
	localparam logic [3:0] S_DOT    = 4'd12;
	localparam logic [3:0] S_DONE   = 4'd13;

	logic [3:0] st_q;
	logic [1:0] i_q, t_q;
	logic h_q, wt_q;

	// triangle store, corner c axis k at 3c+k
	logic signed [CRD_W-1:0] pos_q [9];
	logic signed [NRM_W-1:0] nrm_q [9];
	logic signed [CRD_W-1:0] hq [3];

	acc_t cr_q [9];
	acc_t f_q [3];
	logic [ACC_W-1:0] m3_q, m9_q, msk_q;
	logic [DIV_DW-1:0] sq_q [3];
	logic [DIV_DW-1:0] r_q;
	logic [SQ_RW-1:0] len_q, u_q, v_q;
	logic signed [NRM_W-1:0] face_q [3];
	logic signed [NRM_W-1:0] ip_q [3];
	logic signed [CRD_W-1:0] pl_q, sd_q;
	logic deg_q;

	logic m_tvalid_q;
	logic [OUT_DW-1:0] mdata_q;
	logic [OUT_UW-1:0] muser_q;

	// input unpack
	logic in_func;
	logic [1:0] in_slot;
	logic signed [CRD_W-1:0] in_pos [3];
	logic signed [NRM_W-1:0] in_nrm [3];

	assign in_func = s_tuser[0];
	assign in_slot = s_tuser[2:1];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			in_pos[k] = s_tdata[k*CRD_W +: CRD_W];
			in_nrm[k] = s_tdata[3*CRD_W + k*NRM_W +: NRM_W];
		end
	end

	// edge and offset vectors
	dif_t e1 [3], e2 [3], e3 [3], d2 [3], d3 [3], h1 [3];
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			e1[k] = dif_t'(pos_q[3+k]) - dif_t'(pos_q[k]);
			e2[k] = dif_t'(pos_q[6+k]) - dif_t'(pos_q[k]);
			e3[k] = dif_t'(pos_q[6+k]) - dif_t'(pos_q[3+k]);
			d2[k] = dif_t'(hq[k]) - dif_t'(pos_q[3+k]);
			d3[k] = dif_t'(hq[k]) - dif_t'(pos_q[6+k]);
			h1[k] = dif_t'(hq[k]) - dif_t'(pos_q[k]);
		end
	end

	// cross operand pick: group i_q, axis t_q, half h_q
	dif_t ga [3], gb [3];
	logic [1:0] k1, k2;
	always_comb begin
		case (i_q)
			2'd0: begin
				ga = e1;
				gb = e2;
			end
			2'd1: begin
				ga = e3;
				gb = d2;
			end
			default: begin
				ga = e2;
				gb = d3;
			end
		endcase
		k1 = nxt3(t_q);
		k2 = nxt3(k1);
	end

	// weights
	logic signed [SQ_RW+1:0] w_s;
	assign w_s = $signed(WGT_ONE - {2'b00, u_q} - {2'b00, v_q});

	// unit interfaces
	mac_cmd_t mac_cmd;
	mop_t mac_a, mac_b;
	logic mac_done;
	acc_t mac_acc;
	logic div_go, div_done;
	logic [DIV_NW-1:0] div_num, div_quo;
	logic [DIV_DW-1:0] div_den, rnum;
	logic sq_go, sq_done;
	logic [SQ_XW-1:0] sq_x;
	logic [SQ_RW-1:0] sq_root;
	logic mac_st;
	logic [ACC_W-1:0] fa_w;
	logic [46:0] fnum;
	logic [3:0] gi;

	assign rnum = (i_q == 2'd0) ? sq_q[1] : sq_q[2];
	assign gi   = idx9(i_q, t_q);

	always_comb begin
		mac_st = (st_q == S_CROSS) || (st_q == S_SQF) || (st_q == S_SQG) ||
			(st_q == S_INTERP) || (st_q == S_DOT);
		mac_cmd.go    = mac_st && !wt_q;
		mac_cmd.first = (st_q == S_CROSS) ? !h_q : (t_q == 2'd0);
		mac_cmd.sub   = (st_q == S_CROSS) && h_q;
		mac_a = '0;
		mac_b = '0;
		case (st_q)
			S_CROSS: begin
				mac_a = mop_t'(h_q ? ga[k2] : ga[k1]);
				mac_b = mop_t'(h_q ? gb[k1] : gb[k2]);
			end
			S_SQF: begin
				mac_a = mop_t'($signed(f_q[t_q][CRD_W-1:0]));
				mac_b = mac_a;
			end
			S_SQG: begin
				mac_a = mop_t'($signed(cr_q[gi][CRD_W-1:0]));
				mac_b = mac_a;
			end
			S_INTERP: begin
				case (t_q)
					2'd0:    mac_a = $signed({2'b00, u_q});
					2'd1:    mac_a = $signed({2'b00, v_q});
					default: mac_a = w_s;
				endcase
				mac_b = mop_t'(nrm_q[idx9(t_q, i_q)]);
			end
			S_DOT: begin
				mac_a = mop_t'(face_q[t_q]);
				mac_b = (i_q == 2'd0) ? mop_t'(pos_q[t_q]) : mop_t'(h1[t_q]);
			end
			default: begin
				mac_a = '0;
				mac_b = '0;
			end
		endcase

		fa_w = mag_acc(f_q[t_q]);
		fnum = ({15'b0, fa_w[CRD_W-1:0]} << NRM_FRAC) + {16'b0, len_q[SQ_RW-1:1]};
		div_go = ((st_q == S_FACE) || ((st_q == S_RATIO) && (rnum != '0))) && !wt_q;
		if (st_q == S_FACE) begin
			div_num = {49'b0, fnum};
			div_den = {32'b0, len_q};
		end else begin
			div_num = {rnum, 32'b0};
			div_den = sq_q[0];
		end

		sq_go = ((st_q == S_SQRTL) || (st_q == S_ROOT)) && !wt_q;
		sq_x  = (st_q == S_SQRTL) ? sq_q[0] : r_q;
	end

	tni_mac u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (mac_cmd),
		.a      (mac_a),
		.b      (mac_b),
		.done   (mac_done),
		.acc    (mac_acc)
	);

	tni_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (div_go),
		.num    (div_num),
		.den    (div_den),
		.done   (div_done),
		.quo    (div_quo)
	);

	tni_sqrt u_sqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (sq_go),
		.x      (sq_x),
		.done   (sq_done),
		.root   (sq_root)
	);

	logic nrm_shr, nrm_shl;
	logic [NRM_W-1:0] q16;
	assign nrm_shr = |msk_q[ACC_W-1:NORM_BITS];
	assign nrm_shl = !msk_q[NORM_BITS-1];
	assign q16     = div_quo[NRM_W-1:0];

	assign s_tready = (st_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= S_IDLE;
			i_q        <= '0;
			t_q        <= '0;
			h_q        <= 1'b0;
			wt_q       <= 1'b0;
			deg_q      <= 1'b0;
			m_tvalid_q <= 1'b0;
			mdata_q    <= '0;
			muser_q    <= '0;
			pos_q      <= '{default: '0};
			nrm_q      <= '{default: '0};
			hq         <= '{default: '0};
			cr_q       <= '{default: '0};
			f_q        <= '{default: '0};
			m3_q       <= '0;
			m9_q       <= '0;
			msk_q      <= '0;
			sq_q       <= '{default: '0};
			r_q        <= '0;
			len_q      <= '0;
			u_q        <= '0;
			v_q        <= '0;
			face_q     <= '{default: '0};
			ip_q       <= '{default: '0};
			pl_q       <= '0;
			sd_q       <= '0;
		end else begin
			if (m_tvalid_q && m_tready) m_tvalid_q <= 1'b0;
			if (mac_cmd.go || div_go || sq_go) wt_q <= 1'b1;
			if (mac_done || div_done || sq_done) wt_q <= 1'b0;

			case (st_q)
				S_IDLE: begin
					if (s_tvalid) begin
						if (in_func == FN_QUERY) begin
							hq    <= in_pos;
							m3_q  <= '0;
							m9_q  <= '0;
							deg_q <= 1'b0;
							i_q   <= '0;
							t_q   <= '0;
							h_q   <= 1'b0;
							st_q  <= S_CROSS;
						end else if (in_slot < NUM_SLOTS) begin
							for (int k = 0; k < 3; k++) begin
								pos_q[idx9(in_slot, 2'(k))] <= in_pos[k];
								nrm_q[idx9(in_slot, 2'(k))] <= in_nrm[k];
							end
						end
					end
				end
				S_CROSS: begin
					if (mac_done) begin
						if (!h_q) begin
							h_q <= 1'b1;
						end else begin
							h_q <= 1'b0;
							cr_q[gi] <= mac_acc;
							m9_q <= m9_q | mag_acc(mac_acc);
							if (i_q == 2'd0) m3_q <= m3_q | mag_acc(mac_acc);
							if (t_q == 2'd2) begin
								t_q <= '0;
								if (i_q == 2'd2) begin
									i_q  <= '0;
									st_q <= S_CHECK;
								end else begin
									i_q <= i_q + 2'd1;
								end
							end else begin
								t_q <= t_q + 2'd1;
							end
						end
					end
				end
				S_CHECK: begin
					if (m3_q == '0) begin
						deg_q <= 1'b1;
						st_q  <= S_DONE;
					end else begin
						for (int k = 0; k < 3; k++) f_q[k] <= cr_q[k];
						msk_q <= m3_q;
						st_q  <= S_NRM3;
					end
				end
				S_NRM3: begin
					if (nrm_shr) begin
						msk_q <= msk_q >> 1;
						for (int k = 0; k < 3; k++) f_q[k] <= f_q[k] >>> 1;
					end else if (nrm_shl) begin
						msk_q <= msk_q << 1;
						for (int k = 0; k < 3; k++) f_q[k] <= f_q[k] <<< 1;
					end else begin
						t_q  <= '0;
						st_q <= S_SQF;
					end
				end
				S_SQF: begin
					if (mac_done) begin
						if (t_q == 2'd2) begin
							sq_q[0] <= mac_acc[DIV_DW-1:0];
							t_q     <= '0;
							st_q    <= S_SQRTL;
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_SQRTL: begin
					if (sq_done) begin
						len_q <= sq_root;
						t_q   <= '0;
						st_q  <= S_FACE;
					end
				end
				S_FACE: begin
					if (div_done) begin
						face_q[t_q] <= f_q[t_q][ACC_W-1] ? $signed(-q16) : $signed(q16);
						if (t_q == 2'd2) begin
							t_q   <= '0;
							msk_q <= m9_q;
							st_q  <= S_NRM9;
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_NRM9: begin
					if (nrm_shr) begin
						msk_q <= msk_q >> 1;
						for (int k = 0; k < 9; k++) cr_q[k] <= cr_q[k] >>> 1;
					end else if (nrm_shl) begin
						msk_q <= msk_q << 1;
						for (int k = 0; k < 9; k++) cr_q[k] <= cr_q[k] <<< 1;
					end else begin
						i_q  <= '0;
						t_q  <= '0;
						st_q <= S_SQG;
					end
				end
				S_SQG: begin
					if (mac_done) begin
						if (t_q == 2'd2) begin
							sq_q[i_q] <= mac_acc[DIV_DW-1:0];
							t_q <= '0;
							if (i_q == 2'd2) begin
								i_q  <= '0;
								st_q <= S_RATIO;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_RATIO: begin
					if (!wt_q && (rnum == '0)) begin
						r_q  <= '0;
						st_q <= S_ROOT;
					end else if (div_done) begin
						// quotient at or above 2^62 saturates, also for a zero divisor
						r_q  <= (|div_quo[DIV_NW-1:DIV_DW-2]) ? RATIO_MAX :
							{2'b00, div_quo[DIV_DW-3:0]};
						st_q <= S_ROOT;
					end
				end
				S_ROOT: begin
					if (sq_done) begin
						if (i_q == 2'd0) begin
							u_q  <= sq_root;
							i_q  <= 2'd1;
							st_q <= S_RATIO;
						end else begin
							v_q  <= sq_root;
							i_q  <= '0;
							t_q  <= '0;
							st_q <= S_INTERP;
						end
					end
				end
				S_INTERP: begin
					if (mac_done) begin
						if (t_q == 2'd2) begin
							ip_q[i_q] <= rnd_sat16(mac_acc);
							t_q <= '0;
							if (i_q == 2'd2) begin
								i_q  <= '0;
								st_q <= S_DOT;
							end else begin
								i_q <= i_q + 2'd1;
							end
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_DOT: begin
					if (mac_done) begin
						if (t_q == 2'd2) begin
							t_q <= '0;
							if (i_q == 2'd0) begin
								pl_q <= rnd_sat32(mac_acc);
								i_q  <= 2'd1;
							end else begin
								sd_q <= rnd_sat32(mac_acc);
								i_q  <= '0;
								st_q <= S_DONE;
							end
						end else begin
							t_q <= t_q + 2'd1;
						end
					end
				end
				S_DONE: begin
					if (!m_tvalid_q || m_tready) begin
						mdata_q <= deg_q ? '0 : {sd_q, pl_q, face_q[2], face_q[1], face_q[0],
							ip_q[2], ip_q[1], ip_q[0]};
						muser_q    <= deg_q;
						m_tvalid_q <= 1'b1;
						st_q       <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = mdata_q;
	assign m_tuser  = muser_q;

	// only one arithmetic unit is ever started at a time
	a_one_unit: assert property (@(posedge clk) disable iff (!arst_n)
		$countones({mac_cmd.go, div_go, sq_go}) <= 1)
		else $error("two arithmetic units started together");

	// a unit finishes only while the sequencer waits for it
	a_done_waited: assert property (@(posedge clk) disable iff (!arst_n)
		(mac_done || div_done || sq_done) |-> wt_q)
		else $error("unit finished with no request pending");

	// a degenerate result carries all-zero data
	a_deg_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0))
		else $error("degenerate result with nonzero data");

	// a query beat closes the input until its result is built
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0]) |=> !s_tready)
		else $error("input open right after a query");

endmodule

FILE: tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the triangle normal interpolator: corner loads and
// point queries go in on the slave stream, and every result beat is compared
// field by field with a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module testbench;
	import tni_pkg::*;

	typedef logic signed [127:0] wide_t;
	typedef wide_t wide9_t [9];

	// one result beat, fields in packing order
	typedef struct {
		logic signed [NRM_W-1:0] interp [3];
		logic signed [NRM_W-1:0] face [3];
		logic signed [CRD_W-1:0] plane_offset;
		logic signed [CRD_W-1:0] signed_distance;
		logic                    degenerate;
	} shade_t;

	logic              clk;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [IN_DW-1:0]  s_tdata;   // pos_x, pos_y, pos_z, nrm_in_x, nrm_in_y, nrm_in_z
	logic [IN_UW-1:0]  s_tuser;   // func, vertex_slot
	logic              m_tvalid;
	logic              m_tready;
	logic [OUT_DW-1:0] m_tdata;   // interp xyz, face xyz, plane_offset, signed_distance
	logic [OUT_UW-1:0] m_tuser;   // degenerate

	// shadow of the stored triangle, corner c axis k at 3c+k
	longint corner_pos [9];
	longint corner_nrm [9];

	shade_t pending_shades [$];
	int     fail_count;
	int     load_count;
	int     query_count;
	int     degen_count;
	int     shade_count;
	bit     quiet;   // no idling on either side while set
	int     ready_hold;

	triangle_normal_interpolator u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// mostly back to back, sometimes a short gap, rarely a long hole
	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (quiet || r < 65) return 0;
		if (r < 95) return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	// ---------------- predictor ----------------

	function automatic int mag_bits(wide_t a);
		wide_t m;
		int i;
		m = (a < 0) ? -a : a;
		for (i = 127; i >= 0; i--)
			if (m[i]) return i + 1;
		return 0;
	endfunction

	// shift a group so that its largest magnitude has 31 bits, floor on the right
	function automatic longint scale31(wide_t a, int bl);
		wide_t t;
		t = (bl > NORM_BITS) ? (a >>> (bl - NORM_BITS)) : (a <<< (NORM_BITS - bl));
		return longint'(t[63:0]);
	endfunction

	function automatic logic [63:0] sum_sq(longint a, longint b, longint c);
		return 64'(a * a) + 64'(b * b) + 64'(c * c);
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] x);
		logic [63:0] r;
		logic [63:0] b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b = b >> 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	// floor(a * 2^32 / b), clamped
	function automatic logic [63:0] area_ratio(logic [63:0] a, logic [63:0] b);
		logic [95:0] q;
		if (b == 0) return (a != 0) ? RATIO_MAX : 64'd0;
		if (a / b >= (64'd1 << 30)) return RATIO_MAX;
		q = {a, 32'd0} / {32'd0, b};
		return q[63:0];
	endfunction

	function automatic longint clamp(wide_t x, int w);
		wide_t mx;
		mx = (wide_t'(1) <<< (w - 1)) - 1;
		if (x > mx) return longint'(mx);
		if (x < -mx - 1) return longint'(-mx - 1);
		return longint'(x);
	endfunction

	function automatic void cross_prod(longint a [3], longint b [3], ref wide9_t o,
		input int base);
		o[base]     = wide_t'(a[1]) * b[2] - wide_t'(a[2]) * b[1];
		o[base + 1] = wide_t'(a[2]) * b[0] - wide_t'(a[0]) * b[2];
		o[base + 2] = wide_t'(a[0]) * b[1] - wide_t'(a[1]) * b[0];
	endfunction

	function automatic shade_t predict_shade(longint hp [3]);
		shade_t      s;
		longint      e1 [3], e2 [3], e3 [3], d2 [3], d3 [3], h1 [3];
		longint      f [3], g [9], fn [3];
		wide9_t      cr;
		wide_t       acc;
		logic [63:0] len, base, mag, q;
		longint      u, v, w;
		int          k, bl;
		for (k = 0; k < 3; k++) begin
			e1[k] = corner_pos[3 + k] - corner_pos[k];
			e2[k] = corner_pos[6 + k] - corner_pos[k];
			e3[k] = corner_pos[6 + k] - corner_pos[3 + k];
			d2[k] = hp[k] - corner_pos[3 + k];
			d3[k] = hp[k] - corner_pos[6 + k];
			h1[k] = hp[k] - corner_pos[k];
			s.interp[k] = '0;
			s.face[k] = '0;
		end
		s.plane_offset = '0;
		s.signed_distance = '0;
		s.degenerate = 1'b0;
		cross_prod(e1, e2, cr, 0);
		cross_prod(e3, d2, cr, 3);
		cross_prod(e2, d3, cr, 6);
		if (cr[0] == 0 && cr[1] == 0 && cr[2] == 0) begin
			s.degenerate = 1'b1;
			return s;
		end
		// unit face normal, from the face cross product alone
		bl = 0;
		for (k = 0; k < 3; k++) if (mag_bits(cr[k]) > bl) bl = mag_bits(cr[k]);
		for (k = 0; k < 3; k++) f[k] = scale31(cr[k], bl);
		len = root_floor(sum_sq(f[0], f[1], f[2]));
		for (k = 0; k < 3; k++) begin
			mag = 64'((f[k] < 0) ? -f[k] : f[k]) << NRM_FRAC;
			q = (mag + len / 2) / len;
			fn[k] = (f[k] < 0) ? -longint'(q) : longint'(q);
			s.face[k] = fn[k][NRM_W-1:0];
		end
		// weights: all nine products share one scale
		bl = 0;
		for (k = 0; k < 9; k++) if (mag_bits(cr[k]) > bl) bl = mag_bits(cr[k]);
		for (k = 0; k < 9; k++) g[k] = scale31(cr[k], bl);
		base = sum_sq(g[0], g[1], g[2]);
		u = longint'(root_floor(area_ratio(sum_sq(g[3], g[4], g[5]), base)));
		v = longint'(root_floor(area_ratio(sum_sq(g[6], g[7], g[8]), base)));
		w = (longint'(1) << WGT_FRAC) - u - v;
		for (k = 0; k < 3; k++) begin
			acc = wide_t'(u) * corner_nrm[k] + wide_t'(v) * corner_nrm[3 + k]
				+ wide_t'(w) * corner_nrm[6 + k];
			s.interp[k] = NRM_W'(clamp((acc + (wide_t'(1) <<< (WGT_FRAC - 1))) >>> WGT_FRAC,
				NRM_W));
		end
		acc = wide_t'(fn[0]) * corner_pos[0] + wide_t'(fn[1]) * corner_pos[1]
			+ wide_t'(fn[2]) * corner_pos[2];
		s.plane_offset = CRD_W'(clamp((acc + (wide_t'(1) <<< (NRM_FRAC - 1))) >>> NRM_FRAC,
			CRD_W));
		acc = wide_t'(fn[0]) * h1[0] + wide_t'(fn[1]) * h1[1] + wide_t'(fn[2]) * h1[2];
		s.signed_distance = CRD_W'(clamp((acc + (wide_t'(1) <<< (NRM_FRAC - 1))) >>> NRM_FRAC,
			CRD_W));
		return s;
	endfunction

	// ---------------- driver ----------------

	// Send one beat; the predictor runs once the beat is taken.
	task automatic push_beat(logic fn, logic [1:0] slot, logic [31:0] px, logic [31:0] py,
		logic [31:0] pz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		int     gap;
		int     k;
		longint hp [3];
		gap = gap_len();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= {slot, fn};
		s_tdata  <= {nz, ny, nx, pz, py, px};
		do @(posedge clk); while (!s_tready);
		hp[0] = longint'(signed'(px));
		hp[1] = longint'(signed'(py));
		hp[2] = longint'(signed'(pz));
		if (fn == FN_LOAD) begin
			load_count++;
			if (slot < NUM_SLOTS) begin
				for (k = 0; k < 3; k++) corner_pos[3 * slot + k] = hp[k];
				corner_nrm[3 * slot]     = longint'(signed'(nx));
				corner_nrm[3 * slot + 1] = longint'(signed'(ny));
				corner_nrm[3 * slot + 2] = longint'(signed'(nz));
			end
		end else begin
			query_count++;
			pending_shades.insert(pending_shades.size(), predict_shade(hp));
		end
	endtask

	task automatic load_corner(logic [1:0] slot, logic [31:0] px, logic [31:0] py,
		logic [31:0] pz, logic [15:0] nx, logic [15:0] ny, logic [15:0] nz);
		push_beat(FN_LOAD, slot, px, py, pz, nx, ny, nz);
	endtask

	// random normal data rides along with queries too; the block must ignore it
	task automatic query_point(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		push_beat(FN_QUERY, 2'($urandom_range(0, 3)), px, py, pz, 16'($urandom),
			16'($urandom), 16'($urandom));
	endtask

	// ---------------- result checker ----------------

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$display("%0t: mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
			fail_count++;
		end
	endtask

	task automatic check_shade();
		shade_t e;
		int     k;
		if (pending_shades.size() == 0) begin
			$display("%0t: result beat with nothing expected, data %h degenerate %b",
				$time, m_tdata, m_tuser);
			fail_count++;
			return;
		end
		e = pending_shades.pop_front();
		shade_count++;
		if (e.degenerate) degen_count++;
		for (k = 0; k < 3; k++) begin
			check_field($sformatf("interp[%0d]", k), e.interp[k],
				longint'(signed'(m_tdata[k*NRM_W +: NRM_W])));
			check_field($sformatf("face[%0d]", k), e.face[k],
				longint'(signed'(m_tdata[(3+k)*NRM_W +: NRM_W])));
		end
		check_field("plane_offset", e.plane_offset,
			longint'(signed'(m_tdata[6*NRM_W +: CRD_W])));
		check_field("signed_distance", e.signed_distance,
			longint'(signed'(m_tdata[6*NRM_W+CRD_W +: CRD_W])));
		check_field("degenerate", e.degenerate, m_tuser[0]);
	endtask

	// output side: check on each taken beat, then pick the next ready value
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready   <= 1'b0;
			ready_hold = 0;
		end else begin
			if (m_tvalid && m_tready) check_shade();
			if (ready_hold > 0) begin
				ready_hold--;
				m_tready <= 1'b0;
			end else begin
				ready_hold = gap_len();
				m_tready <= (ready_hold == 0);
			end
		end
	end

	// ---------------- stimulus helpers ----------------

	function automatic logic [31:0] rand_coord(int mode);
		case (mode)
			0: return $urandom;                                           // anything
			1: return 32'($urandom_range(0, 32'h0FFFFF)) - 32'h80000;     // +-8 units
			default: return 32'($urandom_range(0, 32'h3FFFFFF)) - 32'h2000000;
		endcase
	endfunction

	function automatic logic [15:0] rand_normal();
		if ($urandom_range(0, 2) == 0) return 16'($urandom);
		return 16'($urandom_range(0, 32768)) - 16'd16384;   // within +-1.0
	endfunction

	// ---------------- tests ----------------

	// before any load the triangle is all zero, so queries are degenerate
	task automatic test_empty_triangle();
		query_point(32'h0, 32'h0, 32'h0);
		query_point(32'h7FFFFFFF, 32'h80000000, 32'h12345678);
	endtask

	task automatic test_unit_triangle();
		load_corner(2'd0, 32'h0, 32'h0, 32'h0, 16'h4000, 16'h0, 16'h0);
		load_corner(2'd1, 32'h10000, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0);
		load_corner(2'd2, 32'h0, 32'h10000, 32'h0, 16'h0, 16'h0, 16'h4000);
		query_point(32'h4000, 32'h4000, 32'h0);
		query_point(32'h0, 32'h0, 32'h10000);        // corner, above the face
		query_point(32'h0, 32'h0, 32'hFFFF0000);      // below the face
		// load to the missing slot changes nothing
		load_corner(NUM_SLOTS, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF,
			16'h8000, 16'h8000, 16'h8000);
		query_point(32'h8000, 32'h2000, 32'h0);
		// point far off: weights and the blend saturate
		query_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
	endtask

	task automatic test_extremes();
		load_corner(2'd0, 32'h7FFFFFFF, 32'h80000000, 32'h0, 16'h7FFF, 16'h8000, 16'h7FFF);
		load_corner(2'd1, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 16'h8000, 16'h7FFF, 16'h8000);
		load_corner(2'd2, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 16'h7FFF, 16'h7FFF, 16'h8000);
		query_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		query_point(32'h80000000, 32'h80000000, 32'h80000000);
		query_point(32'h0, 32'h0, 32'h0);
		query_point(32'hFFFFFFFF, 32'h1, 32'hFFFFFFFF);
	endtask

	// zero area: repeated corner, then three points on a line
	task automatic test_degenerate();
		load_corner(2'd0, 32'h10000, 32'h20000, 32'h30000, 16'h1000, 16'h2000, 16'h3000);
		load_corner(2'd1, 32'h10000, 32'h20000, 32'h30000, 16'h1000, 16'h2000, 16'h3000);
		load_corner(2'd2, 32'h50000, 32'h0, 32'h0, 16'h0, 16'h4000, 16'h0);
		query_point(32'h20000, 32'h10000, 32'h0);
		load_corner(2'd1, 32'h20000, 32'h40000, 32'h60000, 16'h1000, 16'h2000, 16'h3000);
		load_corner(2'd2, 32'h30000, 32'h60000, 32'h90000, 16'h0, 16'h4000, 16'h0);
		query_point(32'h0, 32'h0, 32'h0);
	endtask

	task automatic test_random(int target);
		int          sent;
		int          nq, i, k, mode, order;
		logic [1:0]  slot;
		logic [31:0] c [3];
		logic [31:0] base [3];
		sent = 0;
		while (sent < target) begin
			quiet = ($urandom_range(0, 9) == 0);
			mode = $urandom_range(0, 2);
			if ($urandom_range(0, 7) == 0) begin
				// noise: a lone load, maybe to the missing slot, or a query as is
				if ($urandom_range(0, 1))
					load_corner(2'($urandom_range(0, 3)), $urandom, $urandom, $urandom,
						16'($urandom), 16'($urandom), 16'($urandom));
				else
					query_point($urandom, $urandom, $urandom);
				sent++;
			end else begin
				// whole triangle, corners in a random order
				order = $urandom_range(0, 2);
				for (k = 0; k < 3; k++) base[k] = rand_coord(mode);
				for (i = 0; i < 3; i++) begin
					slot = 2'((i + order) % 3);
					if ($urandom_range(0, 15) == 0 && i > 0) begin
						// sometimes repeat the corner before to get zero area
					end else begin
						for (k = 0; k < 3; k++) base[k] = rand_coord(mode);
					end
					load_corner(slot, base[0], base[1], base[2], rand_normal(),
						rand_normal(), rand_normal());
					sent++;
				end
				nq = $urandom_range(1, 3);
				for (i = 0; i < nq; i++) begin
					for (k = 0; k < 3; k++)
						c[k] = ($urandom_range(0, 3) == 0) ? $urandom : rand_coord(mode);
					query_point(c[0], c[1], c[2]);
					sent++;
				end
			end
		end
		quiet = 1'b0;
	endtask

	initial begin
		arst_n      = 1'b0;
		s_tvalid    = 1'b0;
		s_tdata     = '0;
		s_tuser     = '0;
		fail_count  = 0;
		load_count  = 0;
		query_count = 0;
		degen_count = 0;
		shade_count = 0;
		quiet       = 1'b0;
		for (int k = 0; k < 9; k++) begin
			corner_pos[k] = 0;
			corner_nrm[k] = 0;
		end
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_triangle();
		test_unit_triangle();
		test_extremes();
		test_degenerate();
		test_random(600);

		s_tvalid <= 1'b0;
		while (pending_shades.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);

		$display("Covered %0d load beats and %0d query beats; %0d results checked,",
			load_count, query_count, shade_count);
		$display("%0d of them on zero-area triangles.", degen_count);
		if (fail_count == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// the timeout leaves several times the slowest expected run
	initial begin
		#(12 * 8000000);
		$display("%0t: timeout, %0d results still pending", $time, pending_shades.size());
		$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
rtl/core/tni_pkg.sv
rtl/core/tni_mac.sv
rtl/core/tni_div.sv
rtl/core/tni_sqrt.sv
rtl/core/triangle_normal_interpolator.sv
tb/testbench.sv
